### src/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// types and constants shared by the sobel edge magnitude blocks
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int SUMSQ_W    = 21;

  localparam logic [FW_W-1:0] FW_RESET     = 11'd1024;
  localparam logic [FH_W-1:0] FH_RESET     = 13'd768;
  localparam logic [FH_W-1:0] HEIGHT_LIMIT = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CH_W-1:0]    EDGE_CLAMP  = 8'd255;
  // largest sum of squares whose rounded root stays at or below the clamp
  localparam logic [SUMSQ_W-1:0] CLAMP_LIMIT = 21'd65280;

  localparam int Q_DEPTH = 2;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t [8:0] win;
    logic         last;
  } item_t;

endpackage

### src/sem_if.sv
// ----------------------------------------------------------------------------
// sem_if
// valid/ready stream interfaces for pixels in and edge magnitudes out
// ----------------------------------------------------------------------------
interface sem_pix_if import sem_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic            drain;
  modport source (output valid, red, green, blue, drain, input ready);
  modport sink (input valid, red, green, blue, drain, output ready);
endinterface

interface sem_edge_if import sem_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] edge_red;
  logic [CH_W-1:0] edge_green;
  logic [CH_W-1:0] edge_blue;
  logic            frame_last;
  modport source (output valid, edge_red, edge_green, edge_blue, frame_last, input ready);
  modport sink (input valid, edge_red, edge_green, edge_blue, frame_last, output ready);
endinterface

### src/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/sem_queue.sv
// ----------------------------------------------------------------------------
// sem_queue
// short queue of masked windows between the front and back parts
// ----------------------------------------------------------------------------
module sem_queue import sem_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t din,
  input  logic  pop,
  output item_t dout,
  output logic  empty,
  output logic  full
);

  localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCW = $clog2(Q_DEPTH + 1);

  item_t          mem [Q_DEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic [QCW-1:0] cnt;

  assign empty = (cnt == '0);
  assign full  = (cnt == QCW'(Q_DEPTH));
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == QAW'(Q_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == QAW'(Q_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

### src/sem_front.sv
// ----------------------------------------------------------------------------
// sem_front
// raster position tracking, line stores, 3x3 window and frame edge masking
// ----------------------------------------------------------------------------
module sem_front import sem_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sem_pix_if.sink               pix_in,
  input  logic                  q_full,
  output logic                  q_push,
  output item_t                 q_item
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_WRITE = 1'b1;

  logic            st;
  logic [FW_W-1:0] fw;
  logic [FH_W-1:0] fh;
  logic [CW-1:0]   col;
  logic [FH_W-1:0] row;
  logic [CW-1:0]   col_q;
  logic [FH_W-1:0] row_q;
  pixel_t          pix_q;
  pixel_t          win [9];

  logic [WW-1:0]   w_eff;
  logic [FH_W-1:0] h_eff;
  logic            restart;
  logic [CW-1:0]   col_s;
  logic [FH_W-1:0] row_s;
  logic            accept;
  pixel_t          up_rd;
  pixel_t          mid_rd;
  pixel_t          win_next [9];
  logic            emit;
  logic            last;
  logic signed [15:0] qr;
  logic signed [15:0] qc;
  logic [2:0]      rv;
  logic [2:0]      cv;
  logic [CW-1:0]   col_next;
  logic [FH_W-1:0] row_next;

  always_comb begin
    if (fw == '0) begin
      w_eff = WW'(1);
    end else if (32'(fw) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw);
    end
    if (fh == '0) begin
      h_eff = FH_W'(1);
    end else if (fh > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end else begin
      h_eff = fh;
    end
  end

  assign restart = (32'(col) >= 32'(w_eff)) || (32'(row) > 32'(h_eff) + 32'd1);
  assign col_s   = restart ? '0 : col;
  assign row_s   = restart ? '0 : row;

  assign pix_in.ready = (st == ST_IDLE) && !q_full;
  assign accept       = pix_in.valid && pix_in.ready;

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (st == ST_WRITE),
    .waddr (col_q),
    .wdata (mid_rd),
    .raddr (col_s),
    .rdata (up_rd)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (st == ST_WRITE),
    .waddr (col_q),
    .wdata (pix_q),
    .raddr (col_s),
    .rdata (mid_rd)
  );

  always_comb begin
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic [31:0]        ncol;
    for (int r = 0; r < 3; r++) begin
      win_next[r*3]     = win[r*3+1];
      win_next[r*3+1]   = win[r*3+2];
    end
    win_next[2] = up_rd;
    win_next[5] = mid_rd;
    win_next[8] = pix_q;

    emit = (row_q >= FH_W'(2)) || ((row_q == FH_W'(1)) && (col_q != '0));
    if (col_q != '0) begin
      qr = $signed(16'(row_q)) - 16'sd1;
      qc = $signed(16'(col_q)) - 16'sd1;
    end else begin
      qr = $signed(16'(row_q)) - 16'sd2;
      qc = $signed(16'(w_eff)) - 16'sd1;
    end
    for (int r = 0; r < 3; r++) begin
      y = qr + $signed(16'(r)) - 16'sd1;
      x = qc + $signed(16'(r)) - 16'sd1;
      rv[r] = (y >= 16'sd0) && (y < $signed(16'(h_eff)));
      cv[r] = (x >= 16'sd0) && (x < $signed(16'(w_eff)));
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        q_item.win[r*3+c] = (rv[r] && cv[c]) ? win_next[r*3+c] : '0;
      end
    end
    last        = (32'(row_q) == 32'(h_eff) + 32'd1) && (col_q == '0);
    q_item.last = last;

    ncol = 32'(col_q) + 32'd1;
    if (emit && last) begin
      col_next = '0;
      row_next = '0;
    end else if (ncol == 32'(w_eff)) begin
      col_next = '0;
      row_next = row_q + 1'b1;
    end else begin
      col_next = CW'(ncol);
      row_next = row_q;
    end
  end

  assign q_push = (st == ST_WRITE) && emit;

  always_ff @(posedge clk) begin
    if (accept) begin
      col_q <= col_s;
      row_q <= row_s;
      pix_q <= pix_in.drain ? '0 : {pix_in.blue, pix_in.green, pix_in.red};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= ST_IDLE;
      fw  <= FW_RESET;
      fh  <= FH_RESET;
      col <= '0;
      row <= '0;
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (accept) begin
            st <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          st  <= ST_IDLE;
          win <= win_next;
          col <= col_next;
          row <= row_next;
        end
        default: st <= ST_IDLE;
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  fw <= cfg_data[FW_W-1:0];
          REG_FRAME_HEIGHT: fh <= cfg_data[FH_W-1:0];
          default: ;
        endcase
        col <= '0;
        row <= '0;
      end
    end
  end

endmodule

### src/sem_back.sv
// ----------------------------------------------------------------------------
// sem_back
// sobel sums, bit-serial rounded square root and output register
// ----------------------------------------------------------------------------
module sem_back import sem_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  item_t     q_head,
  input  logic      q_empty,
  output logic      q_pop,
  sem_edge_if.source edge_out
);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_SUM   = 2'd1;
  localparam logic [1:0] B_ITER  = 2'd2;
  localparam logic [1:0] B_ROUND = 2'd3;

  logic [1:0]         st;
  item_t              item;
  logic [SUMSQ_W-1:0] n [3];
  logic [SUMSQ_W-1:0] n_next [3];
  logic [2:0]         big;
  logic [CH_W-1:0]    s [3];
  logic [CH_W-1:0]    s_iter [3];
  logic [CH_W-1:0]    res [3];
  logic [2:0]         step;
  logic               ovalid;
  logic [CH_W-1:0]    o_r;
  logic [CH_W-1:0]    o_g;
  logic [CH_W-1:0]    o_b;
  logic               o_last;
  logic               load;

  assign q_pop = (st == B_IDLE) && !q_empty;
  assign load  = (st == B_ROUND) && (!ovalid || edge_out.ready);

  always_comb begin
    logic signed [11:0] p [9];
    logic signed [11:0] gx;
    logic signed [11:0] gy;
    logic [23:0]        sqx;
    logic [23:0]        sqy;
    logic [CH_W-1:0]    t;
    logic [15:0]        tt;
    logic [15:0]        ss;
    logic [SUMSQ_W-1:0] rem;
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        p[k] = $signed({4'b0, item.win[k][CH_W*ch +: CH_W]});
      end
      gx  = p[2] - p[0] + 12'sd2 * (p[5] - p[3]) + p[8] - p[6];
      gy  = p[6] - p[0] + 12'sd2 * (p[7] - p[1]) + p[8] - p[2];
      sqx = 24'(gx * gx);
      sqy = 24'(gy * gy);
      n_next[ch] = SUMSQ_W'(sqx + sqy);

      t  = s[ch] | (CH_W'(1) << step);
      tt = 16'(t) * 16'(t);
      s_iter[ch] = (SUMSQ_W'(tt) <= n[ch]) ? t : s[ch];

      ss  = 16'(s[ch]) * 16'(s[ch]);
      rem = n[ch] - SUMSQ_W'(ss);
      if (big[ch]) begin
        res[ch] = EDGE_CLAMP;
      end else if (rem > SUMSQ_W'(s[ch])) begin
        res[ch] = s[ch] + 1'b1;
      end else begin
        res[ch] = s[ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_head;
    end
    unique case (st)
      B_SUM: begin
        for (int ch = 0; ch < 3; ch++) begin
          n[ch]   <= n_next[ch];
          big[ch] <= n_next[ch] > CLAMP_LIMIT;
          s[ch]   <= '0;
        end
      end
      B_ITER: s <= s_iter;
      default: ;
    endcase
    if (load) begin
      o_r    <= res[0];
      o_g    <= res[1];
      o_b    <= res[2];
      o_last <= item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= B_IDLE;
      step   <= '0;
      ovalid <= 1'b0;
    end else begin
      unique case (st)
        B_IDLE: begin
          if (q_pop) begin
            st <= B_SUM;
          end
        end
        B_SUM: begin
          st   <= B_ITER;
          step <= 3'd7;
        end
        B_ITER: begin
          step <= step - 1'b1;
          if (step == '0) begin
            st <= B_ROUND;
          end
        end
        B_ROUND: begin
          if (load) begin
            st <= B_IDLE;
          end
        end
        default: st <= B_IDLE;
      endcase
      if (load) begin
        ovalid <= 1'b1;
      end else if (edge_out.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  assign edge_out.valid      = ovalid;
  assign edge_out.edge_red   = o_r;
  assign edge_out.edge_green = o_g;
  assign edge_out.edge_blue  = o_b;
  assign edge_out.frame_last = o_last;

endmodule

### src/sobel_edge_magnitude_rgb_core.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_core
// 3x3 sobel gradient magnitude per rgb channel over a raster pixel stream
// ----------------------------------------------------------------------------
// In the front part an input pixel takes a line store read, then a write and
// window update. Each pixel that produces a result then passes the back part:
// it takes the window from the queue, forms the sobel sums and squares, runs
// the bit-serial square root iterations for the three channels in parallel,
// then rounds and clamps into the output register. The back part takes no new
// window until the output register is loaded, so the square root unit sets
// the sustained rate; pixels with no result pass through the front part only.
// A two-entry queue decouples the parts. Writing either register restarts the
// frame. Send frame_width+1 drain items after each frame.
module sobel_edge_magnitude_rgb_core import sem_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sem_pix_if.sink               pix_in,
  sem_edge_if.source            edge_out
);

  logic  q_push;
  logic  q_pop;
  logic  q_empty;
  logic  q_full;
  item_t q_in;
  item_t q_head;

  sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  sem_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty),
    .full  (q_full)
  );

  sem_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_head   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .edge_out (edge_out)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("window pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("window popped from empty queue");

  a_ready_room: assert property (@(posedge clk) disable iff (rst) pix_in.ready |-> !q_full)
    else $error("pixel accepted with no queue room");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !edge_out.valid)
    else $error("output valid right after reset");

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sobel_edge_magnitude_rgb_core. Feeds whole frames
// with their drain items, first from a directed table, then at random small
// frame sizes. Every accepted pixel runs through a
// local Sobel predictor. Every accepted result is checked against the oldest
// expected edge magnitude. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import sem_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW        = 1024;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 400;

  typedef struct packed {
    logic [CH_W-1:0] er;
    logic [CH_W-1:0] eg;
    logic [CH_W-1:0] eb;
    logic            last;
  } edge_t;

  typedef enum logic [1:0] {ROW_WIDTH, ROW_HEIGHT, ROW_PIXEL} row_kind_e;

  typedef struct {
    row_kind_e       kind;
    logic [12:0]     data;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    bit              d;
    bit              typed;
    edge_t           exp;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sem_pix_if  pix ();
  sem_edge_if edg ();

  sobel_edge_magnitude_rgb_core #(.MAX_WIDTH(MAXW)) u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pix_in(pix), .edge_out(edg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [PIX_W-1:0] upper_mem [MAXW];
  logic [PIX_W-1:0] middle_mem [MAXW];
  logic [PIX_W-1:0] win [9];
  int unsigned col_pos, row_pos;
  logic [FW_W-1:0] fw;
  logic [FH_W-1:0] fh;

  edge_t edge_q[$];
  int errors = 0;
  int pixels_sent = 0;
  int edges_seen = 0;
  int frames_run = 0;
  bit bench_go = 0;

  stim_t dir_tbl [17] = '{
    '{ROW_WIDTH,  13'd0, 0, 0, 0, 0, 0, '0},
    '{ROW_HEIGHT, 13'd0, 0, 0, 0, 0, 0, '0},
    '{ROW_PIXEL,  0, 8'd255, 8'd0, 8'd128, 0, 0, '0},
    '{ROW_PIXEL,  0, 8'hAA, 8'h55, 8'hFF, 1, 0, '0},
    '{ROW_PIXEL,  0, 8'd255, 8'd255, 8'd255, 0, 1, '{8'd0, 8'd0, 8'd0, 1'b1}},
    '{ROW_WIDTH,  13'd3, 0, 0, 0, 0, 0, '0},
    '{ROW_HEIGHT, 13'd2, 0, 0, 0, 0, 0, '0},
    '{ROW_PIXEL,  0, 8'd255, 8'd255, 8'd255, 0, 0, '0},
    '{ROW_PIXEL,  0, 8'd0, 8'd0, 8'd0, 0, 0, '0},
    '{ROW_PIXEL,  0, 8'd255, 8'd0, 8'd255, 0, 0, '0},
    '{ROW_PIXEL,  0, 8'd255, 8'd255, 8'd255, 1, 0, '0},
    '{ROW_PIXEL,  0, 8'd255, 8'd255, 8'd255, 0, 0, '0},
    '{ROW_PIXEL,  0, 8'd0, 8'd255, 8'd0, 0, 0, '0},
    '{ROW_PIXEL,  0, 8'd0, 8'd0, 8'd0, 1, 0, '0},
    '{ROW_PIXEL,  0, 8'd255, 8'd255, 8'd255, 0, 0, '0},
    '{ROW_PIXEL,  0, 8'd0, 8'd0, 8'd0, 1, 0, '0},
    '{ROW_PIXEL,  0, 8'd9, 8'd200, 8'd77, 1, 0, '0}
  };

  function automatic int eff_width();
    return (fw == 0) ? 1 : ((fw > MAXW) ? MAXW : int'(fw));
  endfunction

  function automatic int eff_height();
    return (fh == 0) ? 1 : ((fh > HEIGHT_LIMIT) ? int'(HEIGHT_LIMIT) : int'(fh));
  endfunction

  function automatic int round_root(int n);
    int s, t;
    s = 0;
    for (int k = 15; k >= 0; k--) begin
      t = s | (1 << k);
      if (t * t <= n) s = t;
    end
    if (n - s * s > s) s++;
    return s;
  endfunction

  function automatic bit sobel_step(input logic [7:0] r, g, b, input bit d, output edge_t res);
    int w, h, c, rr, qr, qc, y, x, gx, gy, v, kx, ky, m;
    bit rv[3], cv[3];
    logic [PIX_W-1:0] px;
    logic [CH_W-1:0] mags[3];
    w = eff_width();
    h = eff_height();
    c = col_pos;
    rr = row_pos;
    res = '0;
    if (c >= w || rr > h + 1) begin
      c = 0;
      rr = 0;
    end
    px = d ? '0 : {b, g, r};
    for (int i = 0; i < 3; i++) begin
      win[i*3] = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = upper_mem[c];
    win[5] = middle_mem[c];
    win[8] = px;
    upper_mem[c] = middle_mem[c];
    middle_mem[c] = px;
    if (!(rr >= 2 || (rr == 1 && c >= 1))) begin
      c++;
      if (c == w) begin
        c = 0;
        rr++;
      end
      col_pos = c;
      row_pos = rr;
      return 0;
    end
    if (c >= 1) begin
      qr = rr - 1;
      qc = c - 1;
    end else begin
      qr = rr - 2;
      qc = w - 1;
    end
    for (int i = 0; i < 3; i++) begin
      y = qr - 1 + i;
      x = qc - 1 + i;
      rv[i] = (y >= 0) && (y < h);
      cv[i] = (x >= 0) && (x < w);
    end
    for (int ch = 0; ch < 3; ch++) begin
      gx = 0;
      gy = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (rv[i] && cv[j]) begin
            v = (win[i*3+j] >> (8 * ch)) & 8'hFF;
            kx = (j - 1) * ((i == 1) ? 2 : 1);
            ky = (i - 1) * ((j == 1) ? 2 : 1);
            gx += v * kx;
            gy += v * ky;
          end
        end
      end
      m = round_root(gx * gx + gy * gy);
      mags[ch] = (m > EDGE_CLAMP) ? EDGE_CLAMP : m[7:0];
    end
    res.er = mags[0];
    res.eg = mags[1];
    res.eb = mags[2];
    res.last = (rr == h + 1) && (c == 0);
    if (res.last) begin
      c = 0;
      rr = 0;
    end else begin
      c++;
      if (c == w) begin
        c = 0;
        rr++;
      end
    end
    col_pos = c;
    row_pos = rr;
    return 1;
  endfunction

  task automatic settle();
    pix.valid <= 1'b0;
    while (edge_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [12:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) fw = data[FW_W-1:0];
    else fh = data[FH_W-1:0];
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic send_pixel(input logic [7:0] r, g, b, input bit d,
                            input bit typed, input edge_t typed_exp);
    int gap;
    edge_t res;
    bit got;
    if (pixels_sent == 250) begin
      pix.valid <= 1'b0;
      @(posedge clk);
      while (edge_q.size() != 0) @(posedge clk);
    end
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.red <= r;
    pix.green <= g;
    pix.blue <= b;
    pix.drain <= d;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    got = sobel_step(r, g, b, d, res);
    if (got) edge_q.push_back(typed ? typed_exp : res);
    pixels_sent++;
  endtask

  task automatic run_frame(input bit noisy);
    int w, h;
    bit d;
    w = eff_width();
    h = eff_height();
    for (int p = 0; p < w * h + w + 1; p++) begin
      if (p < w * h) d = noisy && ($urandom_range(0, 9) == 0);
      else d = !(noisy && ($urandom_range(0, 3) == 0));
      send_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                 d, 0, '0);
    end
    frames_run++;
  endtask

  // result side
  initial begin
    int gap;
    bit held;
    edge_t want;
    held = 0;
    edg.ready <= 1'b0;
    wait (bench_go);
    forever begin
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (edges_seen == 40 && !held) begin
        held = 1;
        gap = 400;
      end
      if (gap > 0) begin
        edg.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      edg.ready <= 1'b1;
      @(posedge clk);
      while (!edg.valid) @(posedge clk);
      edges_seen++;
      if (edge_q.size() == 0) begin
        $error("edge transaction with nothing expected");
        errors++;
      end else begin
        want = edge_q.pop_front();
        if (edg.edge_red !== want.er) begin
          $error("edge_red expected %0d got %0d", want.er, edg.edge_red);
          errors++;
        end
        if (edg.edge_green !== want.eg) begin
          $error("edge_green expected %0d got %0d", want.eg, edg.edge_green);
          errors++;
        end
        if (edg.edge_blue !== want.eb) begin
          $error("edge_blue expected %0d got %0d", want.eb, edg.edge_blue);
          errors++;
        end
        if (edg.frame_last !== want.last) begin
          $error("frame_last expected %0d got %0d", want.last, edg.frame_last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  int quiet = 0;
  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (edg.valid && edg.ready) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int start_items;
    pix.valid <= 1'b0;
    pix.red <= '0;
    pix.green <= '0;
    pix.blue <= '0;
    pix.drain <= 1'b0;
    for (int i = 0; i < MAXW; i++) begin
      upper_mem[i] = '0;
      middle_mem[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
    fw = FW_RESET;
    fh = FH_RESET;
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    bench_go = 1;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      case (dir_tbl[i].kind)
        ROW_WIDTH: reg_write(REG_FRAME_WIDTH, dir_tbl[i].data);
        ROW_HEIGHT: reg_write(REG_FRAME_HEIGHT, dir_tbl[i].data);
        default: send_pixel(dir_tbl[i].r, dir_tbl[i].g, dir_tbl[i].b, dir_tbl[i].d,
                            dir_tbl[i].typed, dir_tbl[i].exp);
      endcase
    end

    start_items = pixels_sent;
    while (pixels_sent - start_items < RANDOM_ITEMS) begin
      reg_write(REG_FRAME_WIDTH, $urandom_range(1, 8));
      reg_write(REG_FRAME_HEIGHT, $urandom_range(1, 6));
      repeat ($urandom_range(1, 3)) run_frame($urandom_range(0, 2) == 0);
    end

    reg_write(REG_FRAME_HEIGHT, 13'd4096);
    reg_write(REG_FRAME_WIDTH, 13'd2);
    reg_write(REG_FRAME_HEIGHT, 13'd3);
    run_frame(1);

    pix.valid <= 1'b0;
    while (edge_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("%0d pixels in %0d random frames plus directed rows, %0d edge results checked",
             pixels_sent, frames_run, edges_seen);
    $display("frame sizes from 1x1 up to 8x6 with drain and noise items, a long output stall");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
